// ===== sv/bd3_pkg.sv =====
// Shared constants and control types for the 3D box difference pipeline.
// No dependencies; imported by every module of the block.
package bd3_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_AXES = 3;
	localparam int NUM_PIECES = 2 * NUM_AXES;

	typedef struct packed {
		logic valid;
		logic hit;
	} isect_ctl_t;

	typedef struct packed {
		logic                  valid;
		logic                  whole;
		logic [NUM_PIECES-1:0] keep;
	} cut_ctl_t;

endpackage

// ===== sv/box_difference_3d_unit.sv =====
// Top level of the 3D box difference block: subtracts box B from box A.
// Depends on bd3_pkg, bd3_isect, bd3_cut and bd3_emit.
//
//   Channel   Handshake                Payload
//   request   in_valid / in_stall      a_low_*, a_high_*, b_low_*, b_high_*
//   result    out_valid / out_stall    piece_low_*, piece_high_*, last_piece
//
// A request passes two register stages, then the output stage sends its pieces one per
// cycle while the result channel is not stalled; a request yields at most six pieces.
// A request that yields no piece leaves no result. Reset clears all valid flags.
// A stall on the result channel backs up through each stage in turn; nothing is lost.
module box_difference_3d_unit #(
	parameter int COORD_BITS = bd3_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] a_low_x,
	input  logic [COORD_BITS-1:0] a_low_y,
	input  logic [COORD_BITS-1:0] a_low_z,
	input  logic [COORD_BITS-1:0] a_high_x,
	input  logic [COORD_BITS-1:0] a_high_y,
	input  logic [COORD_BITS-1:0] a_high_z,
	input  logic [COORD_BITS-1:0] b_low_x,
	input  logic [COORD_BITS-1:0] b_low_y,
	input  logic [COORD_BITS-1:0] b_low_z,
	input  logic [COORD_BITS-1:0] b_high_x,
	input  logic [COORD_BITS-1:0] b_high_y,
	input  logic [COORD_BITS-1:0] b_high_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] piece_low_x,
	output logic [COORD_BITS-1:0] piece_low_y,
	output logic [COORD_BITS-1:0] piece_low_z,
	output logic [COORD_BITS-1:0] piece_high_x,
	output logic [COORD_BITS-1:0] piece_high_y,
	output logic [COORD_BITS-1:0] piece_high_z,
	output logic                  last_piece
);
	import bd3_pkg::*;

	logic [NUM_AXES-1:0][COORD_BITS-1:0] a_lo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] a_hi;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] b_lo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] b_hi;

	isect_ctl_t                          ctl_s1;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] alo_s1;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ahi_s1;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ilo_s1;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ihi_s1;

	cut_ctl_t                            ctl_s2;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] alo_s2;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ahi_s2;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ilo_s2;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] ihi_s2;

	logic [NUM_AXES-1:0][COORD_BITS-1:0] plo_s3;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] phi_s3;

	logic in_ready;
	logic s1_ready;
	logic s2_ready;

	assign a_lo = {a_low_z, a_low_y, a_low_x};
	assign a_hi = {a_high_z, a_high_y, a_high_x};
	assign b_lo = {b_low_z, b_low_y, b_low_x};
	assign b_hi = {b_high_z, b_high_y, b_high_x};
	assign in_stall = !in_ready;

	bd3_isect #(
		.COORD_BITS(COORD_BITS)
	) u_isect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_lo      (a_lo),
		.a_hi      (a_hi),
		.b_lo      (b_lo),
		.b_hi      (b_hi),
		.next_ready(s1_ready),
		.ctl_s1    (ctl_s1),
		.alo_s1    (alo_s1),
		.ahi_s1    (ahi_s1),
		.ilo_s1    (ilo_s1),
		.ihi_s1    (ihi_s1)
	);

	bd3_cut #(
		.COORD_BITS(COORD_BITS)
	) u_cut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.alo_s1    (alo_s1),
		.ahi_s1    (ahi_s1),
		.ilo_s1    (ilo_s1),
		.ihi_s1    (ihi_s1),
		.s1_ready  (s1_ready),
		.next_ready(s2_ready),
		.ctl_s2    (ctl_s2),
		.alo_s2    (alo_s2),
		.ahi_s2    (ahi_s2),
		.ilo_s2    (ilo_s2),
		.ihi_s2    (ihi_s2)
	);

	bd3_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s2   (ctl_s2),
		.alo_s2   (alo_s2),
		.ahi_s2   (ahi_s2),
		.ilo_s2   (ilo_s2),
		.ihi_s2   (ihi_s2),
		.s2_ready (s2_ready),
		.out_stall(out_stall),
		.valid_s3 (out_valid),
		.plo_s3   (plo_s3),
		.phi_s3   (phi_s3),
		.last_s3  (last_piece)
	);

	assign piece_low_x = plo_s3[0];
	assign piece_low_y = plo_s3[1];
	assign piece_low_z = plo_s3[2];
	assign piece_high_x = phi_s3[0];
	assign piece_high_y = phi_s3[1];
	assign piece_high_z = phi_s3[2];

endmodule

// ===== sv/bd3_isect.sv =====
// First pipeline stage: overlap test and per-axis intersection of boxes A and B.
// Depends on bd3_pkg.
module bd3_isect #(
	parameter int COORD_BITS = bd3_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] a_lo,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] a_hi,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] b_lo,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] b_hi,
	input  logic                                       next_ready,
	output bd3_pkg::isect_ctl_t                        ctl_s1,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] alo_s1,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ahi_s1,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ilo_s1,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ihi_s1
);
	import bd3_pkg::*;

	logic [NUM_AXES-1:0][COORD_BITS-1:0] lo_max;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] hi_min;
	logic [NUM_AXES-1:0]                 miss;
	logic                                valid_s1;
	logic                                hit_s1;

	always_comb begin
		for (int d = 0; d < NUM_AXES; d++) begin
			lo_max[d] = ($signed(a_lo[d]) > $signed(b_lo[d])) ? a_lo[d] : b_lo[d];
			hi_min[d] = ($signed(a_hi[d]) < $signed(b_hi[d])) ? a_hi[d] : b_hi[d];
			miss[d] = ($signed(a_lo[d]) > $signed(b_hi[d])) ||
				($signed(a_hi[d]) < $signed(b_lo[d]));
		end
	end

	assign ctl_s1 = {valid_s1, hit_s1};
	assign in_ready = !valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hit_s1 <= ~|miss;
			alo_s1 <= a_lo;
			ahi_s1 <= a_hi;
			ilo_s1 <= lo_max;
			ihi_s1 <= hi_min;
		end
	end

endmodule

// ===== sv/bd3_cut.sv =====
// Second pipeline stage: extent test on the six slabs; on a miss, A passes whole.
// Depends on bd3_pkg; fed by bd3_isect.
module bd3_cut #(
	parameter int COORD_BITS = bd3_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  bd3_pkg::isect_ctl_t                        ctl_s1,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] alo_s1,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ahi_s1,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ilo_s1,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ihi_s1,
	output logic                                       s1_ready,
	input  logic                                       next_ready,
	output bd3_pkg::cut_ctl_t                          ctl_s2,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] alo_s2,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ahi_s2,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ilo_s2,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ihi_s2
);
	import bd3_pkg::*;

	logic [NUM_AXES-1:0]   ext_a;
	logic [NUM_AXES-1:0]   ext_i;
	logic [NUM_AXES-1:0]   lo_cut;
	logic [NUM_AXES-1:0]   hi_cut;
	logic [NUM_PIECES-1:0] keep;
	logic                  rest_ok;
	logic                  valid_s2;
	logic                  whole_s2;
	logic [NUM_PIECES-1:0] keep_s2;

	always_comb begin
		for (int e = 0; e < NUM_AXES; e++) begin
			ext_a[e] = $signed(ahi_s1[e]) > $signed(alo_s1[e]);
			ext_i[e] = $signed(ihi_s1[e]) > $signed(ilo_s1[e]);
			lo_cut[e] = $signed(ilo_s1[e]) > $signed(alo_s1[e]);
			hi_cut[e] = $signed(ahi_s1[e]) > $signed(ihi_s1[e]);
		end
		keep = '0;
		for (int d = 0; d < NUM_AXES; d++) begin
			rest_ok = 1'b1;
			for (int e = 0; e < NUM_AXES; e++) begin
				if (e < d) begin
					rest_ok = rest_ok & ext_i[e];
				end else if (e > d) begin
					rest_ok = rest_ok & ext_a[e];
				end
			end
			keep[2*d] = lo_cut[d] & rest_ok;
			keep[2*d+1] = hi_cut[d] & rest_ok;
		end
		if (!ctl_s1.hit) begin
			keep = NUM_PIECES'(1);
		end
	end

	assign ctl_s2 = {valid_s2, whole_s2, keep_s2};
	assign s1_ready = !valid_s2 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && ctl_s1.valid) begin
			whole_s2 <= !ctl_s1.hit;
			keep_s2 <= keep;
			alo_s2 <= alo_s1;
			ahi_s2 <= ahi_s1;
			ilo_s2 <= ilo_s1;
			ihi_s2 <= ihi_s1;
		end
	end

endmodule

// ===== sv/bd3_emit.sv =====
// Output stage: sends a pair's surviving pieces one per cycle unless stalled; marks last.
// Depends on bd3_pkg; fed by bd3_cut.
module bd3_emit #(
	parameter int COORD_BITS = bd3_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  bd3_pkg::cut_ctl_t                          ctl_s2,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] alo_s2,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ahi_s2,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ilo_s2,
	input  logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] ihi_s2,
	output logic                                       s2_ready,
	input  logic                                       out_stall,
	output logic                                       valid_s3,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] plo_s3,
	output logic [bd3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] phi_s3,
	output logic                                       last_s3
);
	import bd3_pkg::*;

	logic [NUM_PIECES-1:0]               hold_mask_q;
	logic                                hold_whole_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] hold_alo_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] hold_ahi_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] hold_ilo_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] hold_ihi_q;

	logic                                busy;
	logic                                out_free;
	logic                                emit;
	logic [NUM_PIECES-1:0]               src_mask;
	logic [NUM_PIECES-1:0]               pick;
	logic [NUM_PIECES-1:0]               rest;
	logic                                src_whole;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] src_alo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] src_ahi;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] src_ilo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] src_ihi;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] p_lo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] p_hi;

	assign busy = |hold_mask_q;
	assign out_free = !valid_s3 || !out_stall;

	always_comb begin
		if (busy) begin
			src_mask = hold_mask_q;
			src_whole = hold_whole_q;
			src_alo = hold_alo_q;
			src_ahi = hold_ahi_q;
			src_ilo = hold_ilo_q;
			src_ihi = hold_ihi_q;
		end else begin
			src_mask = ctl_s2.valid ? ctl_s2.keep : '0;
			src_whole = ctl_s2.whole;
			src_alo = alo_s2;
			src_ahi = ahi_s2;
			src_ilo = ilo_s2;
			src_ihi = ihi_s2;
		end
	end

	assign pick = src_mask & (~src_mask + NUM_PIECES'(1));
	assign rest = src_mask & ~pick;
	assign emit = out_free && (|src_mask);
	assign s2_ready = !busy && (!ctl_s2.valid || (ctl_s2.keep == '0) || out_free);

	always_comb begin
		p_lo = src_alo;
		p_hi = src_ahi;
		if (!src_whole) begin
			for (int d = 0; d < NUM_AXES; d++) begin
				for (int h = 0; h < 2; h++) begin
					if (pick[2*d+h]) begin
						for (int e = 0; e < NUM_AXES; e++) begin
							if (e < d) begin
								p_lo[e] = src_ilo[e];
								p_hi[e] = src_ihi[e];
							end else if (e > d) begin
								p_lo[e] = src_alo[e];
								p_hi[e] = src_ahi[e];
							end else if (h == 0) begin
								p_lo[e] = src_alo[e];
								p_hi[e] = src_ilo[e];
							end else begin
								p_lo[e] = src_ihi[e];
								p_hi[e] = src_ahi[e];
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_mask_q <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (emit) begin
				hold_mask_q <= rest;
			end
			if (out_free) begin
				valid_s3 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !busy) begin
			hold_whole_q <= ctl_s2.whole;
			hold_alo_q <= alo_s2;
			hold_ahi_q <= ahi_s2;
			hold_ilo_q <= ilo_s2;
			hold_ihi_q <= ihi_s2;
		end
		if (emit) begin
			plo_s3 <= p_lo;
			phi_s3 <= p_hi;
			last_s3 <= (rest == '0);
		end
	end

endmodule
